/* hw/rtl/tslw_pkg.sv */
// ----------------------------------------------------------------------------
// tslw_pkg: shared types and constants
// Event and status codes, register indexes, reset values and the
// reciprocal used to divide the ramp step by one thousand.
// ----------------------------------------------------------------------------
`default_nettype none

package tslw_pkg;

  localparam int KindW   = 3;
  localparam int StatusW = 3;
  localparam int IndexW  = 3;
  localparam int VelW    = 16;
  localparam int LimW    = 15;
  localparam int AccelW  = 16;
  localparam int TimeW   = 32;
  localparam int ElapW   = 16;

  // floor(n / 1000) == (n * RECIP) >> RecipShift for every 32-bit n
  localparam int RecipW      = 33;
  localparam int RecipShift  = 42;
  localparam logic [RecipW-1:0] RECIP = 33'd4398046512;
  localparam int ScaledW     = AccelW + RecipW;
  localparam int ProdW       = ScaledW + ElapW;
  localparam int StepW       = ProdW - RecipShift;

  // event kinds
  localparam logic [KindW-1:0] K_COMMAND  = 3'd0;
  localparam logic [KindW-1:0] K_TICK     = 3'd1;
  localparam logic [KindW-1:0] K_STOP     = 3'd2;
  localparam logic [KindW-1:0] K_SAFE_ON  = 3'd3;
  localparam logic [KindW-1:0] K_SAFE_OFF = 3'd4;
  localparam logic [KindW-1:0] K_MANUAL   = 3'd5;
  localparam logic [KindW-1:0] K_REBASE   = 3'd6;

  // result status
  localparam logic [StatusW-1:0] ST_OK       = 3'd0;
  localparam logic [StatusW-1:0] ST_REJECTED = 3'd1;
  localparam logic [StatusW-1:0] ST_NO_OUT   = 3'd2;
  localparam logic [StatusW-1:0] ST_TIMEOUT  = 3'd3;
  localparam logic [StatusW-1:0] ST_SENT     = 3'd4;

  // register indexes
  localparam logic [IndexW-1:0] R_MAX_LINEAR      = 3'd0;
  localparam logic [IndexW-1:0] R_MAX_ANGULAR     = 3'd1;
  localparam logic [IndexW-1:0] R_LINEAR_ACCEL    = 3'd2;
  localparam logic [IndexW-1:0] R_ANGULAR_ACCEL   = 3'd3;
  localparam logic [IndexW-1:0] R_UPDATE_INTERVAL = 3'd4;
  localparam logic [IndexW-1:0] R_COMMAND_TIMEOUT = 3'd5;

  // reset values
  localparam logic [LimW-1:0]   RST_MAX_LINEAR      = 15'd800;
  localparam logic [LimW-1:0]   RST_MAX_ANGULAR     = 15'd2500;
  localparam logic [AccelW-1:0] RST_LINEAR_ACCEL    = 16'd800;
  localparam logic [AccelW-1:0] RST_ANGULAR_ACCEL   = 16'd3000;
  localparam logic [ElapW-1:0]  RST_UPDATE_INTERVAL = 16'd20;
  localparam logic [TimeW-1:0]  RST_COMMAND_TIMEOUT = 32'd350;

  localparam logic [ScaledW-1:0] RST_LIN_SCALED =
    ScaledW'(RST_LINEAR_ACCEL) * ScaledW'(RECIP);
  localparam logic [ScaledW-1:0] RST_ANG_SCALED =
    ScaledW'(RST_ANGULAR_ACCEL) * ScaledW'(RECIP);

  typedef struct packed {
    logic [LimW-1:0]    max_linear;
    logic [LimW-1:0]    max_angular;
    logic [ScaledW-1:0] lin_scaled;
    logic [ScaledW-1:0] ang_scaled;
    logic [ElapW-1:0]   update_interval;
    logic [TimeW-1:0]   command_timeout;
  } cfg_t;

  function automatic logic signed [VelW-1:0] clamp_sym(
    input logic signed [VelW-1:0] v,
    input logic [LimW-1:0]        lim
  );
    logic signed [VelW:0] l;
    logic signed [VelW:0] vv;
    logic signed [VelW:0] r;
    l  = $signed({2'b00, lim});
    vv = $signed({v[VelW-1], v});
    if (vv < -l) begin
      r = -l;
    end else if (vv > l) begin
      r = l;
    end else begin
      r = vv;
    end
    return r[VelW-1:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/tslw_if.sv */
// ----------------------------------------------------------------------------
// tslw_if: channel interfaces
// Event input, result output and register write channels, each with
// valid/ready and its payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface tslw_evt_if;
  logic                                valid;
  logic                                ready;
  logic [tslw_pkg::KindW-1:0]          kind;
  logic [tslw_pkg::TimeW-1:0]          now_ms;
  logic signed [tslw_pkg::VelW-1:0]    vel_x;
  logic signed [tslw_pkg::VelW-1:0]    vel_y;
  logic signed [tslw_pkg::VelW-1:0]    turn_rate;
  modport source (output valid, kind, now_ms, vel_x, vel_y, turn_rate, input ready);
  modport sink (input valid, kind, now_ms, vel_x, vel_y, turn_rate, output ready);
endinterface

interface tslw_res_if;
  logic                                valid;
  logic                                ready;
  logic [tslw_pkg::StatusW-1:0]        status;
  logic signed [tslw_pkg::VelW-1:0]    out_vx;
  logic signed [tslw_pkg::VelW-1:0]    out_vy;
  logic signed [tslw_pkg::VelW-1:0]    out_wz;
  logic                                is_active;
  logic                                is_blocked;
  modport source (output valid, status, out_vx, out_vy, out_wz, is_active, is_blocked,
                  input ready);
  modport sink (input valid, status, out_vx, out_vy, out_wz, is_active, is_blocked,
                output ready);
endinterface

interface tslw_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tslw_pkg::IndexW-1:0]   index;
  logic [tslw_pkg::TimeW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tslw_cfg.sv */
// ----------------------------------------------------------------------------
// tslw_cfg: register file
// Holds the limits, interval and timeout; stores each ramp rate already
// multiplied by the divide-by-thousand reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

module tslw_cfg (
  input  logic           clk,
  input  logic           rst,
  tslw_cfg_if.sink       cfg,
  output tslw_pkg::cfg_t regs
);

  logic                           wr;
  logic [tslw_pkg::ScaledW-1:0]   data_scaled;

  assign cfg.ready   = 1'b1;
  assign wr          = cfg.valid && cfg.ready;
  assign data_scaled = tslw_pkg::ScaledW'(cfg.data[tslw_pkg::AccelW-1:0])
                     * tslw_pkg::ScaledW'(tslw_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.max_linear      <= tslw_pkg::RST_MAX_LINEAR;
      regs.max_angular     <= tslw_pkg::RST_MAX_ANGULAR;
      regs.lin_scaled      <= tslw_pkg::RST_LIN_SCALED;
      regs.ang_scaled      <= tslw_pkg::RST_ANG_SCALED;
      regs.update_interval <= tslw_pkg::RST_UPDATE_INTERVAL;
      regs.command_timeout <= tslw_pkg::RST_COMMAND_TIMEOUT;
    end else if (wr) begin
      unique case (cfg.index)
        tslw_pkg::R_MAX_LINEAR: begin
          regs.max_linear <= cfg.data[tslw_pkg::LimW-1:0];
        end
        tslw_pkg::R_MAX_ANGULAR: begin
          regs.max_angular <= cfg.data[tslw_pkg::LimW-1:0];
        end
        tslw_pkg::R_LINEAR_ACCEL: begin
          regs.lin_scaled <= data_scaled;
        end
        tslw_pkg::R_ANGULAR_ACCEL: begin
          regs.ang_scaled <= data_scaled;
        end
        tslw_pkg::R_UPDATE_INTERVAL: begin
          regs.update_interval <= cfg.data[tslw_pkg::ElapW-1:0];
        end
        tslw_pkg::R_COMMAND_TIMEOUT: begin
          regs.command_timeout <= cfg.data;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tslw_ramp.sv */
// ----------------------------------------------------------------------------
// tslw_ramp: one-axis slew step
// Moves the current value toward the goal by at most the given step.
// ----------------------------------------------------------------------------
`default_nettype none

module tslw_ramp (
  input  logic signed [tslw_pkg::VelW-1:0]  cur,
  input  logic signed [tslw_pkg::VelW-1:0]  goal,
  input  logic [tslw_pkg::StepW-1:0]        step,
  output logic signed [tslw_pkg::VelW-1:0]  nxt
);

  localparam int W = tslw_pkg::StepW + 2;

  logic signed [W-1:0] c;
  logic signed [W-1:0] g;
  logic signed [W-1:0] s;
  logic signed [W-1:0] up;
  logic signed [W-1:0] dn;

  assign c  = W'(cur);
  assign g  = W'(goal);
  assign s  = $signed({2'b00, step});
  assign up = c + s;
  assign dn = c - s;

  always_comb begin
    priority if (g > up) begin
      nxt = up[tslw_pkg::VelW-1:0];
    end else if (g < dn) begin
      nxt = dn[tslw_pkg::VelW-1:0];
    end else begin
      nxt = goal;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/twist_slew_limiter_watchdog.sv */
// ----------------------------------------------------------------------------
// twist_slew_limiter_watchdog: slew-limited chassis twist with watchdog
// Clamps twist commands, ramps the output on ticks and stops on timeout,
// stop, safety block or blocked manual takeover.
// ----------------------------------------------------------------------------
// One event is taken per clock while the result path keeps up, and each
// gives one result beat: the event is captured in an input register, then
// a single execute step updates the twist state and loads the result register.
// The event channel keeps accepting while a result waits, and stalls only
// while both the input and result registers are full and the result is not
// taken. Registers are written through the configuration channel, which is
// always ready; write them only while no event is in flight.
`default_nettype none

module twist_slew_limiter_watchdog (
  input  logic        clk,
  input  logic        rst,
  tslw_cfg_if.sink    cfg,
  tslw_evt_if.sink    evt,
  tslw_res_if.source  res
);

  localparam int VW = tslw_pkg::VelW;
  localparam int TW = tslw_pkg::TimeW;
  localparam int EW = tslw_pkg::ElapW;
  localparam int PW = tslw_pkg::ProdW;
  localparam int SW = tslw_pkg::StepW;

  tslw_pkg::cfg_t regs;

  tslw_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // input register
  logic                          in_v;
  logic [tslw_pkg::KindW-1:0]    kind_q;
  logic [TW-1:0]                 now_q;
  logic signed [VW-1:0]          vx_q;
  logic signed [VW-1:0]          vy_q;
  logic signed [VW-1:0]          wz_q;
  logic                          exec;

  // twist state
  logic signed [VW-1:0] goal_vx, goal_vy, goal_wz;
  logic signed [VW-1:0] ramp_vx, ramp_vy, ramp_wz;
  logic [TW-1:0]        last_update_time, last_command_time;
  logic                 force_flag, active_flag, blocked_flag;

  logic signed [VW-1:0] goal_vx_next, goal_vy_next, goal_wz_next;
  logic signed [VW-1:0] ramp_vx_next, ramp_vy_next, ramp_wz_next;
  logic [TW-1:0]        last_update_time_next, last_command_time_next;
  logic                 force_flag_next, active_flag_next, blocked_flag_next;
  logic [tslw_pkg::StatusW-1:0] status_next;
  logic                 sent;

  // result register
  logic                          out_v;

  assign exec      = in_v && (!out_v || res.ready);
  assign evt.ready = !in_v || exec;
  assign res.valid = out_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (evt.ready) begin
      in_v <= evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      kind_q <= evt.kind;
      now_q  <= evt.now_ms;
      vx_q   <= evt.vel_x;
      vy_q   <= evt.vel_y;
      wz_q   <= evt.turn_rate;
    end
  end

  // tick timing and ramp steps
  logic [TW-1:0]  dt_cmd, dt_upd, elapsed_raw;
  logic [EW-1:0]  elapsed;
  logic           timed_out, too_soon;
  logic [PW-1:0]  lin_prod, ang_prod;
  logic [SW-1:0]  lin_step, ang_step;
  logic signed [VW-1:0] step_vx, step_vy, step_wz;

  assign dt_cmd      = now_q - last_command_time;
  assign dt_upd      = now_q - last_update_time;
  assign timed_out   = active_flag && (dt_cmd > regs.command_timeout);
  assign too_soon    = !force_flag && (dt_upd < TW'(regs.update_interval));
  assign elapsed_raw = (last_update_time == '0) ? TW'(regs.update_interval) : dt_upd;
  assign elapsed     = (|elapsed_raw[TW-1:EW]) ? {EW{1'b1}} : elapsed_raw[EW-1:0];
  assign lin_prod    = PW'(regs.lin_scaled) * PW'(elapsed);
  assign ang_prod    = PW'(regs.ang_scaled) * PW'(elapsed);
  assign lin_step    = lin_prod[PW-1:tslw_pkg::RecipShift];
  assign ang_step    = ang_prod[PW-1:tslw_pkg::RecipShift];

  tslw_ramp u_ramp_x (.cur(ramp_vx), .goal(goal_vx), .step(lin_step), .nxt(step_vx));
  tslw_ramp u_ramp_y (.cur(ramp_vy), .goal(goal_vy), .step(lin_step), .nxt(step_vy));
  tslw_ramp u_ramp_z (.cur(ramp_wz), .goal(goal_wz), .step(ang_step), .nxt(step_wz));

  always_comb begin
    logic stop;
    stop                   = 1'b0;
    sent                   = 1'b0;
    status_next            = tslw_pkg::ST_OK;
    goal_vx_next           = goal_vx;
    goal_vy_next           = goal_vy;
    goal_wz_next           = goal_wz;
    ramp_vx_next           = ramp_vx;
    ramp_vy_next           = ramp_vy;
    ramp_wz_next           = ramp_wz;
    last_update_time_next  = last_update_time;
    last_command_time_next = last_command_time;
    force_flag_next        = force_flag;
    active_flag_next       = active_flag;
    blocked_flag_next      = blocked_flag;

    unique case (kind_q)
      tslw_pkg::K_COMMAND: begin
        if (blocked_flag) begin
          status_next = tslw_pkg::ST_REJECTED;
        end else begin
          goal_vx_next           = tslw_pkg::clamp_sym(vx_q, regs.max_linear);
          goal_vy_next           = tslw_pkg::clamp_sym(vy_q, regs.max_linear);
          goal_wz_next           = tslw_pkg::clamp_sym(wz_q, regs.max_angular);
          force_flag_next        = 1'b1;
          last_command_time_next = now_q;
          active_flag_next       = 1'b1;
        end
      end
      tslw_pkg::K_TICK: begin
        priority if (blocked_flag) begin
          status_next = tslw_pkg::ST_NO_OUT;
        end else if (timed_out) begin
          stop        = 1'b1;
          status_next = tslw_pkg::ST_TIMEOUT;
        end else if (!active_flag || too_soon) begin
          status_next = tslw_pkg::ST_NO_OUT;
        end else begin
          sent                  = 1'b1;
          status_next           = tslw_pkg::ST_SENT;
          last_update_time_next = now_q;
          force_flag_next       = 1'b0;
          ramp_vx_next          = step_vx;
          ramp_vy_next          = step_vy;
          ramp_wz_next          = step_wz;
        end
      end
      tslw_pkg::K_STOP: begin
        stop = 1'b1;
      end
      tslw_pkg::K_SAFE_ON: begin
        blocked_flag_next = 1'b1;
        stop              = 1'b1;
      end
      tslw_pkg::K_SAFE_OFF: begin
        blocked_flag_next = 1'b0;
      end
      tslw_pkg::K_MANUAL: begin
        if (blocked_flag) begin
          stop        = 1'b1;
          status_next = tslw_pkg::ST_REJECTED;
        end else begin
          active_flag_next = 1'b0;
        end
      end
      tslw_pkg::K_REBASE: begin
        ramp_vx_next          = goal_vx;
        ramp_vy_next          = goal_vy;
        ramp_wz_next          = goal_wz;
        last_update_time_next = now_q;
        force_flag_next       = 1'b1;
      end
      default: begin
        status_next = tslw_pkg::ST_NO_OUT;
      end
    endcase

    if (stop) begin
      goal_vx_next     = '0;
      goal_vy_next     = '0;
      goal_wz_next     = '0;
      ramp_vx_next     = '0;
      ramp_vy_next     = '0;
      ramp_wz_next     = '0;
      force_flag_next  = 1'b1;
      active_flag_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_vx           <= '0;
      goal_vy           <= '0;
      goal_wz           <= '0;
      ramp_vx           <= '0;
      ramp_vy           <= '0;
      ramp_wz           <= '0;
      last_update_time  <= '0;
      last_command_time <= '0;
      force_flag        <= 1'b1;
      active_flag       <= 1'b0;
      blocked_flag      <= 1'b0;
    end else if (exec) begin
      goal_vx           <= goal_vx_next;
      goal_vy           <= goal_vy_next;
      goal_wz           <= goal_wz_next;
      ramp_vx           <= ramp_vx_next;
      ramp_vy           <= ramp_vy_next;
      ramp_wz           <= ramp_wz_next;
      last_update_time  <= last_update_time_next;
      last_command_time <= last_command_time_next;
      force_flag        <= force_flag_next;
      active_flag       <= active_flag_next;
      blocked_flag      <= blocked_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (exec) begin
      out_v <= 1'b1;
    end else if (res.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      res.status     <= status_next;
      res.out_vx     <= sent ? ramp_vx_next : '0;
      res.out_vy     <= sent ? ramp_vy_next : '0;
      res.out_wz     <= sent ? ramp_wz_next : '0;
      res.is_active  <= active_flag_next;
      res.is_blocked <= blocked_flag_next;
    end
  end

  // a ramp output only leaves while enabled and unblocked
  a_sent_active: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status == tslw_pkg::ST_SENT |-> res.is_active && !res.is_blocked)
    else $error("output beat while inactive or blocked");

  // a timeout disables output and carries no twist
  a_timeout_quiet: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.status == tslw_pkg::ST_TIMEOUT |->
      !res.is_active && res.out_vx == '0 && res.out_vy == '0 && res.out_wz == '0)
    else $error("timeout beat with motion");

  // safety stop leaves the block set and motion halted
  a_safe_stop: assert property (@(posedge clk) disable iff (rst)
    exec && kind_q == tslw_pkg::K_SAFE_ON |=>
      blocked_flag && !active_flag && ramp_vx == '0 && ramp_vy == '0 && ramp_wz == '0)
    else $error("safety stop did not halt");

  // state only moves when an event executes
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !exec |=> $stable(ramp_vx) && $stable(goal_vx) && $stable(last_update_time)
      && $stable(blocked_flag))
    else $error("state changed without an event");

endmodule

`default_nettype wire
